// ===== hw/rtl/rdl_pkg.sv =====
package rdl_pkg;

  // Field widths of the stream payload.
  localparam int CIPHER_W = 16;
  localparam int PLAIN_W  = 16;
  localparam int CODE_W   = 7;

  // Step counter: wide enough to walk the cipher bits during the reduction.
  localparam int CNT_W = $clog2(CIPHER_W);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_P  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIME_Q  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 2'd2;

  // Letter mapping constants.
  localparam logic [PLAIN_W-1:0] LETTER_LOW  = 16'd1;
  localparam logic [PLAIN_W-1:0] LETTER_HIGH = 16'd26;
  localparam logic [PLAIN_W-1:0] SPACE_CODE  = 16'd32;
  localparam logic [CODE_W-1:0]  ASCII_A     = 7'h61;
  localparam logic [CODE_W-1:0]  ASCII_SPACE = 7'h20;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              not_letter;
  } letter_t;

  // Maps a plain value to a lowercase letter, a space, or the not-letter flag.
  function automatic letter_t letter_map(input logic [PLAIN_W-1:0] v);
    letter_t res;
    logic [PLAIN_W-1:0] offs;
    offs           = v - LETTER_LOW;
    res.code       = '0;
    res.not_letter = 1'b1;
    if (v >= LETTER_LOW && v <= LETTER_HIGH) begin
      res.code       = ASCII_A + offs[CODE_W-1:0];
      res.not_letter = 1'b0;
    end else if (v == SPACE_CODE) begin
      res.code       = ASCII_SPACE;
      res.not_letter = 1'b0;
    end
    return res;
  endfunction

endpackage

// ===== hw/rtl/rsa_decrypt_to_letter_top.sv =====
// Each item passes a setup step, a bit-serial reduction of the cipher value modulo p*q, and
// one square-and-multiply round per exponent bit on NW = min(MOD_WIDTH, 16) bit operands.
// Items are handled one at a time; the next input is taken as soon as the result is parked
// in the output register. The time per item is set by the bit-serial reduction and multipliers.
// Reset (rst, synchronous, active high) returns the primes to 3 and 11, the exponent to 7,
// and empties the datapath and the output register.
module rsa_decrypt_to_letter_top
  import rdl_pkg::*;
#(
  parameter int MOD_WIDTH = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  // Configuration write channel.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_data,
  // Input stream.
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [15:0]          s_tdata,   // [15:0] cipher_value
  // Output stream.
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [23:0]          m_tdata,   // [15:0] plain_value, [22:16] char_code, [23] zero
  output logic                 m_tuser    // [0] not_letter
);

  // The modulus p*q never exceeds 16 bits, so the datapath is at most that wide.
  localparam int NW = (MOD_WIDTH < 16) ? MOD_WIDTH : 16;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SETUP = 3'd1;
  localparam logic [2:0] ST_RED   = 3'd2;
  localparam logic [2:0] ST_CHECK = 3'd3;
  localparam logic [2:0] ST_MUL   = 3'd4;
  localparam logic [2:0] ST_DONE  = 3'd5;

  // One step of an interleaved modular multiply: r = (2r + din*b) mod n.
  // With r and b below n the sum stays below 3n, so at most two subtractions
  // of n are needed, and both candidates are formed side by side.
  function automatic logic [NW-1:0] mod_step(input logic [NW-1:0] r, input logic din,
                                             input logic [NW-1:0] b, input logic [NW-1:0] n);
    logic [NW+1:0] t;
    logic [NW+1:0] n1;
    logic [NW+1:0] n2;
    t  = {1'b0, r, 1'b0} + (din ? {2'b00, b} : '0);
    n1 = {2'b00, n};
    n2 = {1'b0, n, 1'b0};
    if (t >= n2) begin
      return NW'(t - n2);
    end else if (t >= n1) begin
      return NW'(t - n1);
    end
    return NW'(t);
  endfunction

  // Configuration registers.
  logic [7:0]  prime_p;
  logic [7:0]  prime_q;
  logic [15:0] private_exponent;

  // Datapath.
  logic [2:0]          state;
  logic [CNT_W-1:0]    cnt;
  logic [NW-1:0]       nmod;      // modulus latched for the current item
  logic [15:0]         expo;      // exponent, consumed least significant bit first
  logic [CIPHER_W-1:0] cshift;    // cipher bits fed MSB first into the reduction
  logic [NW-1:0]       acc;       // running power
  logic [NW-1:0]       base;      // running square
  logic [NW-1:0]       ma;        // serial multiplicand for acc*base
  logic [NW-1:0]       mb;        // serial multiplicand for base*base
  logic [NW-1:0]       r1;        // partial product of acc*base
  logic [NW-1:0]       r2;        // partial product of base*base, or cipher residue
  logic [NW-1:0]       r1_next;
  logic [NW-1:0]       r2_next;
  logic [15:0]         nprod;

  // Output register.
  logic                out_valid;
  logic [PLAIN_W-1:0]  out_plain;
  logic [CODE_W-1:0]   out_code;
  logic                out_nl;

  logic [PLAIN_W-1:0]  plain_final;
  letter_t             letter;
  logic                out_free;

  // Neither channel takes a transaction while reset is held.
  assign cfg_ready = !rst;
  assign s_tready  = !rst && (state == ST_IDLE);
  assign m_tvalid  = out_valid;
  assign m_tdata   = {1'b0, out_code, out_plain};
  assign m_tuser   = out_nl;

  assign nprod    = 16'(prime_p) * 16'(prime_q);
  assign out_free = !out_valid || m_tready;

  always_comb begin
    r1_next = mod_step(r1, ma[NW-1], base, nmod);
    if (state == ST_RED) begin
      r2_next = mod_step(r2, cshift[CIPHER_W-1], NW'(1), nmod);
    end else begin
      r2_next = mod_step(r2, mb[NW-1], base, nmod);
    end
  end

  // A zero modulus forces a zero result regardless of the arithmetic.
  assign plain_final = (nmod == '0) ? '0 : PLAIN_W'(acc);
  assign letter      = letter_map(plain_final);

  always_ff @(posedge clk) begin
    if (rst) begin
      prime_p          <= 8'd3;
      prime_q          <= 8'd11;
      private_exponent <= 16'd7;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_PRIME_P:  prime_p          <= cfg_data[7:0];
        CFG_PRIME_Q:  prime_q          <= cfg_data[7:0];
        CFG_EXPONENT: private_exponent <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          cnt   <= '0;
          state <= ST_RED;
        end
        ST_RED: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(CIPHER_W - 1)) begin
            cnt   <= '0;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          cnt <= '0;
          if (expo == '0 || nmod == '0) begin
            state <= ST_DONE;
          end else begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(NW - 1)) begin
            state <= ST_CHECK;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Payload registers of the datapath; no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cshift <= s_tdata[CIPHER_W-1:0];
          expo   <= private_exponent;
        end
      end
      ST_SETUP: begin
        nmod <= nprod[NW-1:0];
        r2   <= '0;
      end
      ST_RED: begin
        r2     <= r2_next;
        cshift <= {cshift[CIPHER_W-2:0], 1'b0};
        if (cnt == CNT_W'(CIPHER_W - 1)) begin
          base <= r2_next;
          acc  <= (nmod == NW'(1)) ? '0 : NW'(1);
        end
      end
      ST_CHECK: begin
        ma <= acc;
        mb <= base;
        r1 <= '0;
        r2 <= '0;
      end
      ST_MUL: begin
        r1 <= r1_next;
        r2 <= r2_next;
        ma <= {ma[NW-2:0], 1'b0};
        mb <= {mb[NW-2:0], 1'b0};
        if (cnt == CNT_W'(NW - 1)) begin
          if (expo[0]) begin
            acc <= r1_next;
          end
          base <= r2_next;
          expo <= {1'b0, expo[15:1]};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && out_free) begin
      out_plain <= plain_final;
      out_code  <= letter.code;
      out_nl    <= letter.not_letter;
    end
  end

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == ST_SETUP)
    else $error("accepted item did not start the setup step");

  a_residues_reduced: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL && nmod != '0) |-> (acc < nmod && base < nmod))
    else $error("running power or square not reduced below the modulus");

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_MUL |-> cnt <= CNT_W'(NW - 1))
    else $error("multiply step counter out of range");

  a_flag_matches_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser == (m_tdata[22:16] == '0)))
    else $error("not-letter flag disagrees with the character code");

  a_result_lower_than_modulus: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && nmod != '0) |-> acc < nmod)
    else $error("result not reduced below the modulus");
`endif

endmodule
